// ===== hw/rtl/complementary_attitude_filter_defines.svh =====
// assertion helpers shared by the attitude filter rtl
`ifndef COMPLEMENTARY_ATTITUDE_FILTER_DEFINES_SVH
`define COMPLEMENTARY_ATTITUDE_FILTER_DEFINES_SVH

// same-cycle implication, off while reset is held
`define CAF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("caf assertion failed");

// next-cycle implication, off while reset is held
`define CAF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("caf assertion failed");

`endif

// ===== hw/rtl/caf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package caf_pkg;

  localparam int CORDIC_STEPS_DEF = 14;
  localparam int DATA_WIDTH_DEF   = 16;

  localparam int ZW     = 20;  // cordic angle, q16 radians
  localparam int QW     = 16;  // output angle, q3.12 radians
  localparam int MA     = 24;  // multiplier operand a
  localparam int MB     = 18;  // multiplier operand b
  localparam int CHUNK  = 17;  // bits of the magnitude per gain product
  localparam int RSW    = 21;  // rate times dt in q3.12
  localparam int SW     = 22;  // pre-saturation sums
  localparam int BIAS_W = 15;

  localparam logic signed [ZW-1:0] PI_Q16   = 20'sd205887;
  localparam logic signed [MB-1:0] INV_GAIN = 18'sd39796;
  localparam logic [16:0]          ONE_Q15  = 17'd32768;

  localparam logic [15:0] BLEND_WEIGHT_RST = 16'd32112;
  localparam logic [15:0] TIME_STEP_RST    = 16'd655;

  localparam logic [BIAS_W-1:0] BIAS_NONE  = 15'd0;
  localparam logic [BIAS_W-1:0] BIAS_RATE  = 15'd2048;
  localparam logic [BIAS_W-1:0] BIAS_BLEND = 15'd16384;

  localparam logic REG_BLEND_WEIGHT = 1'b0;
  localparam logic REG_TIME_STEP    = 1'b1;

  // steps of the multiply-accumulate program after the second cordic pass
  localparam logic [2:0] MS_RATE_X  = 3'd0;
  localparam logic [2:0] MS_RATE_Y  = 3'd1;
  localparam logic [2:0] MS_RATE_Z  = 3'd2;
  localparam logic [2:0] MS_ROLL_A  = 3'd3;
  localparam logic [2:0] MS_ROLL_B  = 3'd4;
  localparam logic [2:0] MS_PITCH_A = 3'd5;
  localparam logic [2:0] MS_PITCH_B = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROLL,
    ST_GAIN,
    ST_LAUNCH,
    ST_PITCH,
    ST_BLEND,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              en;
    logic              clr;
    logic [BIAS_W-1:0] bias;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_stat_t;

  function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      5'd0:    v = 20'sd51472;
      5'd1:    v = 20'sd30386;
      5'd2:    v = 20'sd16055;
      5'd3:    v = 20'sd8150;
      5'd4:    v = 20'sd4091;
      5'd5:    v = 20'sd2047;
      5'd6:    v = 20'sd1024;
      5'd7:    v = 20'sd512;
      5'd8:    v = 20'sd256;
      5'd9:    v = 20'sd128;
      5'd10:   v = 20'sd64;
      5'd11:   v = 20'sd32;
      5'd12:   v = 20'sd16;
      5'd13:   v = 20'sd8;
      5'd14:   v = 20'sd4;
      5'd15:   v = 20'sd2;
      5'd16:   v = 20'sd1;
      default: v = 20'sd0;
    endcase
    return v;
  endfunction

  // q16 angle to q3.12 with round half up
  function automatic logic signed [QW-1:0] q16_to_q12(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] s;
    s = z + 20'sd8;
    return s[ZW-1:4];
  endfunction

  function automatic logic signed [QW-1:0] sat16(input logic signed [SW-1:0] v);
    logic signed [QW-1:0] r;
    if (v > 22'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -22'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/complementary_attitude_filter.sv =====
// channel  direction  handshake             word
// in_      sink       in_valid / in_ready   accel x/y/z counts, gyro x/y/z rates
// out_     source     out_valid / out_ready roll, pitch, yaw in q3.12
// cfg_     sink       cfg_we                cfg_index selects register, cfg_data
//
// a word goes through the single cordic rotator, run twice one step a cycle,
// with a gain correction on the shared multiply-accumulate unit between the
// passes in N slices, N = 2 for DATA_WIDTH up to 16, 3 up to 33, and the
// blend on the same unit after the second pass
// in_ready is high only while idle; a finished word stalls in its last state
// until the output register is free
// synchronous active-low reset clears the estimates and loads the register defaults
`timescale 1ns / 1ps
`default_nettype none
`include "complementary_attitude_filter_defines.svh"

module complementary_attitude_filter import caf_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int DATA_WIDTH   = DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic signed [15:0] in_rate_x,
  input  logic signed [15:0] in_rate_y,
  input  logic signed [15:0] in_rate_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_roll_angle,
  output logic signed [15:0] out_pitch_angle,
  output logic signed [15:0] out_yaw_angle,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int W   = DATA_WIDTH + 19;
  localparam int AW  = W + 17;
  localparam int NCH = (W - 1 + CHUNK - 1) / CHUNK;
  localparam int GCW = $clog2(NCH);
  localparam int SHW = $clog2(CHUNK * (NCH - 1) + 1);

  state_t state_r, state_nxt;
  logic [GCW-1:0] gc_r;
  logic [2:0]     mc_r;

  logic [15:0] blend_weight_r, time_step_r;
  logic [15:0] aw;
  logic [16:0] aw_comp;

  logic signed [15:0]    ax_r, rx_r, ry_r, rz_r;
  logic signed [QW-1:0]  roll_r, pitch_r, yaw_r;
  logic signed [QW-1:0]  acc_roll_r, acc_pitch_r, roll_new_r;
  logic signed [RSW-1:0] rsx_r, rsy_r, rsz_r;
  logic signed [QW-1:0]  out_roll_r, out_pitch_r, out_yaw_r;
  logic                  out_valid_r;
  logic                  out_load;

  logic                  cordic_start;
  logic signed [W-1:0]   cx_in, cy_in, cx_out;
  logic signed [ZW-1:0]  cz_out;
  cordic_stat_t          cordic_stat;

  mac_ctl_t              mac_ctl;
  logic [SHW-1:0]        mac_shamt;
  logic signed [MA-1:0]  mac_a;
  logic signed [MB-1:0]  mac_b;
  logic signed [AW-1:0]  mac_acc;
  logic [W-1:0]          x_shift;
  logic signed [W-1:0]   mag, az_w, ay_w, ax_w;
  logic signed [SW-1:0]  yaw_sum;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_weight_r <= BLEND_WEIGHT_RST;
      time_step_r    <= TIME_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLEND_WEIGHT: blend_weight_r <= cfg_data;
        REG_TIME_STEP:    time_step_r    <= cfg_data;
      endcase
    end
  end

  // alpha above one is used as one
  assign aw      = ({1'b0, blend_weight_r} > ONE_Q15) ? ONE_Q15[15:0] : blend_weight_r;
  assign aw_comp = ONE_Q15 - {1'b0, aw};

  // ---------------- operand forming ----------------
  assign az_w = {{(W - 16 - DATA_WIDTH){in_accel_z[15]}}, in_accel_z, {DATA_WIDTH{1'b0}}};
  assign ay_w = {{(W - 16 - DATA_WIDTH){in_accel_y[15]}}, in_accel_y, {DATA_WIDTH{1'b0}}};
  assign ax_w = {{(W - 16 - DATA_WIDTH){ax_r[15]}}, ax_r, {DATA_WIDTH{1'b0}}};
  // gain-corrected magnitude, floor of x * 1/K
  assign mag  = mac_acc[W+15:16];

  assign cx_in = (state_r == ST_LAUNCH) ? mag : az_w;
  assign cy_in = (state_r == ST_LAUNCH) ? -ax_w : ay_w;

  assign yaw_sum = SW'(yaw_r) + SW'(rsz_r);

  // ---------------- sequencer ----------------
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_ROLL;
      ST_ROLL:   if (cordic_stat.done) state_nxt = ST_GAIN;
      ST_GAIN:   if (gc_r == GCW'(NCH - 1)) state_nxt = ST_LAUNCH;
      ST_LAUNCH: state_nxt = ST_PITCH;
      ST_PITCH:  if (cordic_stat.done) state_nxt = ST_BLEND;
      ST_BLEND:  if (mc_r == MS_PITCH_B) state_nxt = ST_OUT;
      ST_OUT:    if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cordic_start = 1'b0;
    mac_ctl      = '{en: 1'b0, clr: 1'b0, bias: BIAS_NONE};
    mac_shamt    = '0;
    mac_a        = '0;
    mac_b        = '0;
    x_shift      = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cordic_start = in_valid;
      end
      ST_GAIN: begin
        // magnitude times 1/K, one slice of the magnitude per cycle
        mac_shamt = SHW'(CHUNK * gc_r);
        x_shift   = cx_out >> mac_shamt;
        mac_ctl   = '{en: 1'b1, clr: (gc_r == '0), bias: BIAS_NONE};
        mac_a     = MA'(x_shift[CHUNK-1:0]);
        mac_b     = INV_GAIN;
      end
      ST_LAUNCH: cordic_start = 1'b1;
      ST_BLEND: begin
        unique case (mc_r)
          MS_RATE_X: begin
            mac_ctl = '{en: 1'b1, clr: 1'b1, bias: BIAS_RATE};
            mac_a   = MA'(rx_r);
            mac_b   = MB'(time_step_r);
          end
          MS_RATE_Y: begin
            mac_ctl = '{en: 1'b1, clr: 1'b1, bias: BIAS_RATE};
            mac_a   = MA'(ry_r);
            mac_b   = MB'(time_step_r);
          end
          MS_RATE_Z: begin
            mac_ctl = '{en: 1'b1, clr: 1'b1, bias: BIAS_RATE};
            mac_a   = MA'(rz_r);
            mac_b   = MB'(time_step_r);
          end
          MS_ROLL_A: begin
            mac_ctl = '{en: 1'b1, clr: 1'b1, bias: BIAS_BLEND};
            mac_a   = MA'(roll_r) + MA'(rsx_r);
            mac_b   = MB'(aw);
          end
          MS_ROLL_B: begin
            mac_ctl = '{en: 1'b1, clr: 1'b0, bias: BIAS_NONE};
            mac_a   = MA'(acc_roll_r);
            mac_b   = MB'(aw_comp);
          end
          MS_PITCH_A: begin
            mac_ctl = '{en: 1'b1, clr: 1'b1, bias: BIAS_BLEND};
            mac_a   = MA'(pitch_r) + MA'(rsy_r);
            mac_b   = MB'(aw);
          end
          MS_PITCH_B: begin
            mac_ctl = '{en: 1'b1, clr: 1'b0, bias: BIAS_NONE};
            mac_a   = MA'(acc_pitch_r);
            mac_b   = MB'(aw_comp);
          end
          default: begin
            mac_ctl = '{en: 1'b0, clr: 1'b0, bias: BIAS_NONE};
          end
        endcase
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gc_r        <= '0;
      mc_r        <= '0;
      out_valid_r <= 1'b0;
      roll_r      <= '0;
      pitch_r     <= '0;
      yaw_r       <= '0;
    end else begin
      state_r <= state_nxt;
      gc_r    <= (state_r == ST_GAIN) ? gc_r + 1'b1 : '0;
      mc_r    <= (state_r == ST_BLEND) ? mc_r + 3'd1 : '0;
      if (out_load) begin
        out_valid_r <= 1'b1;
        roll_r      <= roll_new_r;
        pitch_r     <= sat16(mac_acc[15+SW-1:15]);
        yaw_r       <= sat16(yaw_sum);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------- datapath capture ----------------
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ax_r <= in_accel_x;
      rx_r <= in_rate_x;
      ry_r <= in_rate_y;
      rz_r <= in_rate_z;
    end
    if (state_r == ST_ROLL && cordic_stat.done) begin
      acc_roll_r <= q16_to_q12(cz_out);
    end
    if (state_r == ST_PITCH && cordic_stat.done) begin
      acc_pitch_r <= q16_to_q12(cz_out);
    end
    if (state_r == ST_BLEND) begin
      if (mc_r == MS_RATE_Y) begin
        rsx_r <= mac_acc[12+RSW-1:12];
      end
      if (mc_r == MS_RATE_Z) begin
        rsy_r <= mac_acc[12+RSW-1:12];
      end
      if (mc_r == MS_ROLL_A) begin
        rsz_r <= mac_acc[12+RSW-1:12];
      end
      if (mc_r == MS_PITCH_A) begin
        roll_new_r <= sat16(mac_acc[15+SW-1:15]);
      end
    end
    if (out_load) begin
      out_roll_r  <= roll_new_r;
      out_pitch_r <= sat16(mac_acc[15+SW-1:15]);
      out_yaw_r   <= sat16(yaw_sum);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_roll_angle  = out_roll_r;
  assign out_pitch_angle = out_pitch_r;
  assign out_yaw_angle   = out_yaw_r;

  // ---------------- shared units ----------------
  caf_cordic #(
    .STEPS (CORDIC_STEPS),
    .W     (W)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .x_in  (cx_in),
    .y_in  (cy_in),
    .x_out (cx_out),
    .z_out (cz_out),
    .stat  (cordic_stat)
  );

  caf_mac #(
    .AW  (AW),
    .SHW (SHW)
  ) u_mac (
    .clk   (clk),
    .ctl   (mac_ctl),
    .shamt (mac_shamt),
    .op_a  (mac_a),
    .op_b  (mac_b),
    .acc   (mac_acc)
  );

  // ---------------- checks ----------------
  `CAF_ASSERT_NXT(a_accept_starts_cordic, clk, rst_n, in_valid && in_ready, cordic_stat.busy)
  `CAF_ASSERT_IMP(a_ready_only_when_free, clk, rst_n, in_ready, !cordic_stat.busy)
  `CAF_ASSERT_IMP(a_done_in_pass_state, clk, rst_n, cordic_stat.done, (state_r == ST_ROLL) || (state_r == ST_PITCH))
  `CAF_ASSERT_NXT(a_yaw_moves_on_load, clk, rst_n, !out_load, $stable(yaw_r))

endmodule

`default_nettype wire

// ===== hw/rtl/caf_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none

module caf_cordic import caf_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF,
  parameter int W     = DATA_WIDTH_DEF + 19
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [W-1:0] x_in,
  input  logic signed [W-1:0] y_in,
  output logic signed [W-1:0] x_out,
  output logic signed [ZW-1:0] z_out,
  output cordic_stat_t        stat
);

  localparam int IW = $clog2(STEPS);

  logic signed [W-1:0]  x_r, y_r, x_nxt, y_nxt, dx, dy;
  logic signed [ZW-1:0] z_r, z_nxt, ang;
  logic [IW-1:0]        i_r;
  logic                 busy_r, done_r, zero_r;

  // one micro-rotation per cycle while busy
  always_comb begin
    dx  = y_r >>> i_r;
    dy  = x_r >>> i_r;
    ang = atan_q16(5'(i_r));
    if (!y_r[W-1]) begin
      x_nxt = x_r + dx;
      y_nxt = y_r - dy;
      z_nxt = z_r + ang;
    end else begin
      x_nxt = x_r - dx;
      y_nxt = y_r + dy;
      z_nxt = z_r - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
      end else if (busy_r) begin
        i_r <= i_r + 1'b1;
        if (i_r == IW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      zero_r <= (x_in == '0) && (y_in == '0);
      // left half plane: pre-rotate by pi
      if (x_in[W-1]) begin
        x_r <= -x_in;
        y_r <= -y_in;
        z_r <= y_in[W-1] ? -PI_Q16 : PI_Q16;
      end else begin
        x_r <= x_in;
        y_r <= y_in;
        z_r <= '0;
      end
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  // zero vector keeps x at zero by itself, only the angle needs forcing
  assign x_out     = x_r;
  assign z_out     = zero_r ? '0 : z_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

// ===== hw/rtl/caf_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none

module caf_mac import caf_pkg::*; #(
  parameter int AW  = DATA_WIDTH_DEF + 36,
  parameter int SHW = 5
) (
  input  logic                 clk,
  input  mac_ctl_t             ctl,
  input  logic [SHW-1:0]       shamt,
  input  logic signed [MA-1:0] op_a,
  input  logic signed [MB-1:0] op_b,
  output logic signed [AW-1:0] acc
);

  localparam int PW = MA + MB;

  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] prod_ext, base, acc_r, acc_nxt;

  always_comb begin
    prod     = op_a * op_b;
    prod_ext = {{(AW - PW){prod[PW-1]}}, prod};
    base     = ctl.clr ? {{(AW - BIAS_W){1'b0}}, ctl.bias} : acc_r;
    acc_nxt  = base + (prod_ext <<< shamt);
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire
